### sv/psbd_pkg.sv
// ----------------------------------------------------------------------------
// psbd_pkg : shared types and constants for the statement boundary detector
// Character codes, quote tracking codes and the per-line state record.
// ----------------------------------------------------------------------------
package psbd_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 255;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // item opcodes
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  // string tracking, one-hot
  typedef enum logic [4:0] {
    QM_NONE   = 5'b00001,  // outside any string
    QM_OPENED = 5'b00010,  // plain string, opening quote just seen
    QM_PLAIN  = 5'b00100,  // inside plain string
    QM_EMPTY  = 5'b01000,  // empty string just closed, third quote goes triple
    QM_TRIPLE = 5'b10000   // inside triple-quoted string
  } psbd_qmode_t;

  typedef struct packed {
    psbd_qmode_t qmode;
    logic        quote_dbl;
    logic        esc;
    logic [1:0]  close_run;
    logic        in_comment;
    logic        line_text;
    logic        last_colon;
    logic        start_zero;   // line began at depth 0
    logic        block_wait;
    logic        pend_text;
  } psbd_state_t;

  typedef struct packed {
    logic line_end;
    logic done;
    logic cont;
    logic opens;
  } psbd_res_t;

  localparam psbd_state_t STATE_RST = '{
    qmode:      QM_NONE,
    quote_dbl:  1'b0,
    esc:        1'b0,
    close_run:  2'd0,
    in_comment: 1'b0,
    line_text:  1'b0,
    last_colon: 1'b0,
    start_zero: 1'b1,
    block_wait: 1'b0,
    pend_text:  1'b0
  };

endpackage

### sv/psbd_step.sv
// ----------------------------------------------------------------------------
// psbd_step : next-state and result logic for one item
// Pure combinational update of the scanner state and bracket depth.
// ----------------------------------------------------------------------------
module psbd_step #(
  parameter int unsigned MAX_DEPTH = psbd_pkg::MAX_DEPTH_DEF,
  parameter int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
  input  logic                 op,
  input  logic [7:0]           ch,
  input  psbd_pkg::psbd_state_t st,
  input  logic [DEPTH_W-1:0]   depth,
  output psbd_pkg::psbd_state_t st_nxt,
  output logic [DEPTH_W-1:0]   depth_nxt,
  output logic [7:0]           bracket_depth,
  output psbd_pkg::psbd_res_t  res
);
  import psbd_pkg::*;

  logic                 ws_ch;
  logic                 is_quote;
  logic [7:0]           q_ch;
  logic                 blank_line;
  logic                 colon_line;
  logic                 pend;
  logic                 do_outside;
  logic [DEPTH_W+7:0]   depth_ext;

  assign ws_ch    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
  assign is_quote = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
  assign q_ch     = st.quote_dbl ? CH_DQUOTE : CH_SQUOTE;

  assign blank_line = !st.line_text;
  assign colon_line = !blank_line && st.start_zero && st.last_colon;
  assign pend       = st.pend_text || st.line_text;

  always_comb begin
    st_nxt     = st;
    depth_nxt  = depth;
    res        = '0;
    do_outside = 1'b0;

    if (op == OP_ABORT) begin
      st_nxt    = STATE_RST;
      depth_nxt = '0;
    end else if (ch == CH_LF) begin
      res.line_end     = 1'b1;
      res.opens        = colon_line;
      st_nxt.pend_text = pend;
      priority if (depth != '0) begin
        // open brackets: keep collecting
      end else if (!blank_line && st.block_wait) begin
        // body line of an open block
      end else if (colon_line) begin
        st_nxt.block_wait = 1'b1;
      end else begin
        if (blank_line) st_nxt.block_wait = 1'b0;
        res.done         = pend;
        st_nxt.pend_text = 1'b0;
      end
      st_nxt.qmode      = QM_NONE;
      st_nxt.quote_dbl  = 1'b0;
      st_nxt.esc        = 1'b0;
      st_nxt.close_run  = 2'd0;
      st_nxt.in_comment = 1'b0;
      st_nxt.line_text  = 1'b0;
      st_nxt.last_colon = 1'b0;
      st_nxt.start_zero = (depth == '0);
    end else begin
      if (!ws_ch) begin
        st_nxt.line_text  = 1'b1;
        st_nxt.last_colon = (ch == CH_COLON);
      end
      if (!st.in_comment) begin
        unique case (st.qmode)
          QM_OPENED, QM_PLAIN: begin
            priority if (st.esc) begin
              st_nxt.esc   = 1'b0;
              st_nxt.qmode = QM_PLAIN;
            end else if (ch == CH_BSLASH) begin
              st_nxt.esc   = 1'b1;
              st_nxt.qmode = QM_PLAIN;
            end else if (ch == q_ch) begin
              st_nxt.qmode = (st.qmode == QM_OPENED) ? QM_EMPTY : QM_NONE;
            end else begin
              st_nxt.qmode = QM_PLAIN;
            end
          end
          QM_TRIPLE: begin
            if (ch == q_ch) begin
              if (st.close_run == 2'd2) begin
                st_nxt.close_run = 2'd0;
                st_nxt.qmode     = QM_NONE;
              end else begin
                st_nxt.close_run = st.close_run + 2'd1;
              end
            end else begin
              st_nxt.close_run = 2'd0;
            end
          end
          QM_EMPTY: begin
            if (ch == q_ch) begin
              st_nxt.qmode     = QM_TRIPLE;
              st_nxt.close_run = 2'd0;
            end else begin
              st_nxt.qmode = QM_NONE;
              do_outside   = 1'b1;
            end
          end
          default: begin
            st_nxt.qmode = QM_NONE;
            do_outside   = 1'b1;
          end
        endcase
      end

      if (do_outside) begin
        priority if (ch == CH_HASH) begin
          st_nxt.in_comment = 1'b1;
        end else if (is_quote) begin
          st_nxt.qmode     = QM_OPENED;
          st_nxt.quote_dbl = (ch == CH_DQUOTE);
        end else if ((ch == CH_LPAREN) || (ch == CH_LBRACK) || (ch == CH_LBRACE)) begin
          if (depth < DEPTH_W'(MAX_DEPTH)) depth_nxt = depth + DEPTH_W'(1);
        end else if ((ch == CH_RPAREN) || (ch == CH_RBRACK) || (ch == CH_RBRACE)) begin
          if (depth != '0) depth_nxt = depth - DEPTH_W'(1);
        end else begin
          // ordinary code byte
        end
      end
    end

    if (op != OP_ABORT) res.cont = (depth_nxt != '0) || st_nxt.block_wait;
  end

  assign depth_ext     = {8'd0, depth_nxt};
  assign bracket_depth = (depth_ext > (DEPTH_W + 8)'(255)) ? 8'hFF : depth_ext[7:0];

endmodule

### sv/python_statement_boundary_detector.sv
// ----------------------------------------------------------------------------
// python_statement_boundary_detector : line-level statement completion check
// Scans a source byte stream and flags complete statements at each newline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_op / in_ch): one transfer per
//   source byte (in_op = 0) or one abort (in_op = 1), which drops all pending
//   input, bracket depth and block state. Every input transfer yields exactly
//   one result transfer on the out_ channel, in order.
//   Results carry the saturated bracket depth (shown as 255 above 255), a
//   line end flag, statement complete, continuation prompt and block opener.
// Timing:
//   Two register stages: an input register and a result register, with the
//   whole scanner update in between. An item moves from the input register
//   into the result register, which raises out_valid; throughput is one
//   item per cycle while out_stall is low, with the scanner state fed back
//   from item to item.
// Stall:
//   While out_stall holds a valid result, the result register freezes; an
//   empty input register still takes one more item, and in_stall is high
//   while it holds an item that cannot move on, so nothing is lost or repeated.
// Reset:
//   rst_n low (synchronous) empties both stages and sets depth 0, outside any
//   string or comment, no block pending, line starting at depth 0.
// ----------------------------------------------------------------------------
module python_statement_boundary_detector #(
  parameter int unsigned MAX_DEPTH = psbd_pkg::MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // source byte / abort input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_ch,
  // per-item result
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_bracket_depth,
  output logic       out_line_end,
  output logic       out_statement_complete,
  output logic       out_continuation_prompt,
  output logic       out_opens_block
);
  import psbd_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  // input register
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_ch_r;

  // scanner state carried from item to item
  psbd_state_t        st_r;
  psbd_state_t        st_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] bd_r;
  psbd_res_t  res_r;
  logic [7:0] bd_nxt;
  psbd_res_t  res_nxt;

  logic advance;   // input stage may move into the result register

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  psbd_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W)
  ) u_step (
    .op            (s1_op_r),
    .ch            (s1_ch_r),
    .st            (st_r),
    .depth         (depth_r),
    .st_nxt        (st_nxt),
    .depth_nxt     (depth_nxt),
    .bracket_depth (bd_nxt),
    .res           (res_nxt)
  );

  // input stage: loads whenever it is empty or handing its item on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op_r <= in_op;
      s1_ch_r <= in_ch;
    end
  end

  // scanner state commits only when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= STATE_RST;
      depth_r <= '0;
    end else if (s1_valid_r && advance) begin
      st_r    <= st_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      bd_r  <= bd_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_bracket_depth       = bd_r;
  assign out_line_end            = res_r.line_end;
  assign out_statement_complete  = res_r.done;
  assign out_continuation_prompt = res_r.cont;
  assign out_opens_block         = res_r.opens;

  // depth never passes its ceiling
  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("bracket depth above limit");

  // an abort leaves no depth and no open block behind
  a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_op_r == OP_ABORT)) |=>
      (depth_r == '0) && !st_r.block_wait && !st_r.pend_text)
    else $error("abort left state behind");

  // completion and block opening are only reported on a newline
  a_done_at_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.done || res_r.opens)) |-> res_r.line_end)
    else $error("line flags without line end");

  // open brackets always ask for more input
  a_depth_prompt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (bd_r != 8'd0)) |-> res_r.cont)
    else $error("open brackets without continuation prompt");

  // an item leaving the input stage always lands in the result register
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("item lost between stages");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : statement boundary detector, self-checking
// Drives source bytes and aborts over the valid/stall input channel, predicts
// every result from its own copy of the scanner state and compares each
// result field by field, under random idling on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
  import psbd_pkg::*;

  // one expected result transfer
  typedef struct packed {
    logic [7:0] depth;
    logic       line_end;
    logic       done;
    logic       cont;
    logic       opens;
  } boundary_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks brackets, strings, comments and blocks per byte and
  // keeps the queue of results still to arrive.
  // --------------------------------------------------------------------------
  class boundary_scoreboard;
    boundary_res_t due_q[$];

    // scanner copy
    int unsigned depth;
    bit          start_zero;
    psbd_qmode_t qmode;
    bit          quote_dbl;
    bit          esc;
    int unsigned close_run;
    bit          in_comment;
    bit          line_text;
    bit          last_colon;
    bit          block_wait;
    bit          pend_text;

    // run statistics
    int n_items;
    int n_checked;
    int n_errors;
    int n_lines;
    int n_done;
    int n_opens;
    int n_aborts;
    int peak_depth;

    function new();
      restart();
    endfunction

    function void clear_line();
      qmode      = QM_NONE;
      quote_dbl  = 1'b0;
      esc        = 1'b0;
      close_run  = 0;
      in_comment = 1'b0;
      line_text  = 1'b0;
      last_colon = 1'b0;
    endfunction

    function void restart();
      depth      = 0;
      start_zero = 1'b1;
      block_wait = 1'b0;
      pend_text  = 1'b0;
      clear_line();
    endfunction

    // byte seen outside any string or comment
    function void outside_byte(logic [7:0] c);
      if (c == CH_HASH) begin
        in_comment = 1'b1;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        qmode     = QM_OPENED;
        quote_dbl = (c == CH_DQUOTE);
      end else if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
        if (depth < MAX_DEPTH_DEF) depth++;
      end else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE) begin
        if (depth > 0) depth--;
      end
    endfunction

    function void scan_byte(logic [7:0] c);
      logic [7:0] q;
      q = quote_dbl ? CH_DQUOTE : CH_SQUOTE;
      if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
        line_text  = 1'b1;
        last_colon = (c == CH_COLON);
      end
      if (in_comment) return;
      case (qmode)
        QM_OPENED, QM_PLAIN: begin
          if (esc) begin
            esc   = 1'b0;
            qmode = QM_PLAIN;
          end else if (c == CH_BSLASH) begin
            esc   = 1'b1;
            qmode = QM_PLAIN;
          end else if (c == q) begin
            qmode = (qmode == QM_OPENED) ? QM_EMPTY : QM_NONE;
          end else begin
            qmode = QM_PLAIN;
          end
        end
        QM_TRIPLE: begin
          if (c == q) begin
            close_run++;
            if (close_run >= 3) begin
              close_run = 0;
              qmode     = QM_NONE;
            end
          end else begin
            close_run = 0;
          end
        end
        QM_EMPTY: begin
          if (c == q) begin
            qmode     = QM_TRIPLE;
            close_run = 0;
          end else begin
            qmode = QM_NONE;
            outside_byte(c);
          end
        end
        default: begin
          qmode = QM_NONE;
          outside_byte(c);
        end
      endcase
    endfunction

    // accepted input transfer: advance the scanner, queue its result
    function void note_item(logic op, logic [7:0] c);
      boundary_res_t r;
      bit blank;
      bit colon;
      r = '0;
      n_items++;
      if (op == OP_ABORT) begin
        restart();
        n_aborts++;
      end else if (c == CH_LF) begin
        blank      = !line_text;
        colon      = !blank && start_zero && last_colon;
        r.line_end = 1'b1;
        r.opens    = colon;
        if (line_text) pend_text = 1'b1;
        // open brackets, or a non-blank line inside a block, keep waiting
        if (depth == 0 && !(!blank && block_wait)) begin
          if (colon) begin
            block_wait = 1'b1;
          end else begin
            if (blank) block_wait = 1'b0;
            if (pend_text) r.done = 1'b1;
            pend_text = 1'b0;
          end
        end
        clear_line();
        start_zero = (depth == 0);
      end else begin
        scan_byte(c);
      end
      r.depth = (depth > 255) ? 8'd255 : 8'(depth);
      r.cont  = (depth != 0) || block_wait;
      if (depth > peak_depth) peak_depth = depth;
      n_lines += r.line_end;
      n_done  += r.done;
      n_opens += r.opens;
      due_q.push_back(r);
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      n_errors++;
      $display("%0t: result %0d, %s: got %0d, expected %0d",
               $time, n_checked, what, got, want);
    endtask

    task check_result(boundary_res_t got);
      boundary_res_t want;
      n_checked++;
      if (due_q.size() == 0) begin
        report_mismatch("result with nothing pending, depth", got.depth, 0);
        return;
      end
      want = due_q.pop_front();
      if (got.depth !== want.depth)
        report_mismatch("bracket_depth", got.depth, want.depth);
      if (got.line_end !== want.line_end)
        report_mismatch("line_end", got.line_end, want.line_end);
      if (got.done !== want.done)
        report_mismatch("statement_complete", got.done, want.done);
      if (got.cont !== want.cont)
        report_mismatch("continuation_prompt", got.cont, want.cont);
      if (got.opens !== want.opens)
        report_mismatch("opens_block", got.opens, want.opens);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = OP_CHAR;
  logic [7:0] in_ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_bracket_depth;
  logic       out_line_end;
  logic       out_statement_complete;
  logic       out_continuation_prompt;
  logic       out_opens_block;

  python_statement_boundary_detector DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_op                   (in_op),
    .in_ch                   (in_ch),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_bracket_depth       (out_bracket_depth),
    .out_line_end            (out_line_end),
    .out_statement_complete  (out_statement_complete),
    .out_continuation_prompt (out_continuation_prompt),
    .out_opens_block         (out_opens_block)
  );

  boundary_scoreboard sb = new();

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender pacing: alternating stretches of back-to-back transfers and of
  // random gaps (mostly short, a few long).
  // --------------------------------------------------------------------------
  int calm_left = 0;
  bit calm = 1'b0;

  function automatic int sender_gap();
    int r;
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(40, 150);
    end
    calm_left--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input transfer. Entered and left right after a rising edge, so each
  // step sees at most one update of in_valid. Handshake signals are read
  // right after the edge, i.e. with their values from before it.
  task automatic send_item(input logic op, input logic [7:0] c);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_ch    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, c);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
  endtask

  // --------------------------------------------------------------------------
  // Source text pieces
  // --------------------------------------------------------------------------
  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] open_byte();
    case ($urandom_range(0, 2))
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      default: return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] close_byte();
    case ($urandom_range(0, 2))
      0:       return CH_RPAREN;
      1:       return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  // anything that may show up inside a string or comment
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 11))
      0, 1:    return "a" + 8'($urandom_range(0, 25));
      2:       return "0" + 8'($urandom_range(0, 9));
      3:       return CH_HASH;
      4:       return CH_COLON;
      5:       return open_byte();
      6:       return close_byte();
      7:       return CH_SQUOTE;
      8:       return CH_DQUOTE;
      9:       return CH_BSLASH;
      10:      return CH_SPACE;
      default: return blank_byte();
    endcase
  endfunction

  task automatic word();
    repeat ($urandom_range(1, 4)) send_item(OP_CHAR, "a" + 8'($urandom_range(0, 25)));
  endtask

  // One line of mixed tokens. Ends with a newline, or, when finish is 0,
  // is cut short by an abort.
  task automatic random_line(input bit finish);
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    repeat ($urandom_range(0, 7)) begin
      case ($urandom_range(0, 19))
        4, 5:      send_item(OP_CHAR, blank_byte());
        6, 7:      send_item(OP_CHAR, open_byte());
        8, 9, 18:  send_item(OP_CHAR, close_byte());
        10, 11: begin
          // plain string, with escapes, sometimes left open
          send_item(OP_CHAR, q);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
              send_item(OP_CHAR, CH_BSLASH);
              send_item(OP_CHAR, $urandom_range(0, 1) ? q : filler_byte());
            end else begin
              send_item(OP_CHAR, filler_byte());
            end
          end
          if ($urandom_range(0, 9) != 0) send_item(OP_CHAR, q);
        end
        12: begin
          // triple string with quote runs inside, sometimes a fourth quote
          repeat (3) send_item(OP_CHAR, q);
          repeat ($urandom_range(0, 6))
            send_item(OP_CHAR, ($urandom_range(0, 3) == 0) ? q : filler_byte());
          if ($urandom_range(0, 7) != 0) begin
            repeat (3) send_item(OP_CHAR, q);
            if ($urandom_range(0, 3) == 0) send_item(OP_CHAR, q);
          end
        end
        13: begin
          send_item(OP_CHAR, CH_HASH);
          repeat ($urandom_range(0, 4)) send_item(OP_CHAR, filler_byte());
        end
        14:      send_item(OP_CHAR, CH_COLON);
        15:      send_item(OP_CHAR, CH_BSLASH);
        16:      send_item(OP_CHAR, 8'($urandom_range(0, 255)));  // raw noise
        17:      send_item(OP_CHAR, q);
        19: begin
          send_item(OP_CHAR, q);
          send_item(OP_CHAR, q);
          word();
        end
        default: word();
      endcase
    end
    if (finish) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_CHAR, CH_COLON);
        if ($urandom_range(0, 1)) send_item(OP_CHAR, blank_byte());
      end
      send_item(OP_CHAR, CH_LF);
    end else begin
      send_item(OP_ABORT, 8'($urandom_range(0, 255)));
    end
  endtask

  // header line ending in ':', an indented body, then a blank line
  task automatic block_stmt();
    word();
    if ($urandom_range(0, 2) == 0) send_item(OP_CHAR, blank_byte());
    send_item(OP_CHAR, CH_COLON);
    send_item(OP_CHAR, CH_LF);
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(1, 2)) send_item(OP_CHAR, blank_byte());
      random_line(1'b1);
    end
    repeat ($urandom_range(0, 2)) send_item(OP_CHAR, blank_byte());
    send_item(OP_CHAR, CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int n_deep;
    bit deep_done;
    deep_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray close at depth 0, block opener with trailing tab/CR,
    // blank line closing the block, extreme byte values, backslash right
    // before a newline inside brackets, triple string closed by a run of
    // four quotes, then an abort in the middle of a line
    send_item(OP_CHAR, CH_RPAREN);
    send_str("a:\t\015\n");
    send_item(OP_CHAR, CH_LF);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, CH_LF);
    send_str("(\"\\\n");
    send_str(")'''#''''\n");
    send_item(OP_CHAR, CH_LBRACK);
    send_item(OP_ABORT, 8'hA5);

    // random part: mostly well-formed statements with random content
    while (sb.n_items < 1925) begin
      if (!deep_done && sb.n_items > 700) begin
        // bracket run past the depth limit, then as many closes, which reach depth 0 early
        deep_done = 1'b1;
        n_deep = 256 + $urandom_range(0, 3);
        send_item(OP_ABORT, 8'($urandom_range(0, 255)));
        repeat (n_deep) send_item(OP_CHAR, open_byte());
        send_item(OP_CHAR, CH_LF);
        repeat (n_deep) send_item(OP_CHAR, close_byte());
        send_item(OP_CHAR, CH_LF);
      end else begin
        case ($urandom_range(0, 19))
          10, 11, 12, 13, 14: block_stmt();
          15, 16: begin
            repeat ($urandom_range(0, 2)) send_item(OP_CHAR, blank_byte());
            send_item(OP_CHAR, CH_LF);
          end
          17: random_line(1'b0);
          18, 19: begin
            // statement spread over lines by open brackets
            send_item(OP_CHAR, open_byte());
            random_line(1'b1);
            random_line(1'b1);
            send_item(OP_CHAR, close_byte());
            send_item(OP_CHAR, CH_LF);
          end
          default: random_line(1'b1);
        endcase
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching the outputs to catch stray results
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d transfers (%0d aborts): %0d line ends, %0d statements complete,",
             sb.n_items, sb.n_aborts, sb.n_lines, sb.n_done);
    $display("%0d block openers, bracket depth up to %0d, %0d mismatches.",
             sb.n_opens, sb.peak_depth, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: checks every transfer and stalls at random. Once, after a
  // few hundred results, it holds off for a long stretch so that the block
  // fills up and stalls its input while the sender keeps offering bytes.
  // --------------------------------------------------------------------------
  initial begin
    boundary_res_t got;
    bit stall_now;
    int run_left;
    bit pressure_done;
    stall_now     = 1'b0;
    run_left      = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.depth    = out_bracket_depth;
        got.line_end = out_line_end;
        got.done     = out_statement_complete;
        got.cont     = out_continuation_prompt;
        got.opens    = out_opens_block;
        sb.check_result(got);
      end
      if (run_left == 0) begin
        if (!pressure_done && sb.n_checked >= 600) begin
          pressure_done = 1'b1;
          stall_now     = 1'b1;
          run_left      = 400;
        end else if (stall_now) begin
          stall_now = 1'b0;
          run_left  = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
        end else begin
          stall_now = 1'b1;
          run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
        end
      end
      run_left--;
      out_stall <= stall_now;
    end
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
sv/psbd_pkg.sv
sv/psbd_step.sv
sv/python_statement_boundary_detector.sv
tb/sv/testbench.sv
